@@ rtl/hts_pkg.sv @@
// Shared types and constants for the two-set Hangul syllable composer.
// No dependencies; hts_step and the top level in rtl/ import this package.
`timescale 1ns / 1ps
package hts_pkg;

    typedef logic [4:0] jamo_t;

    localparam jamo_t NO_JAMO    = 5'd31;
    localparam jamo_t INIT_COUNT = 5'd19;
    localparam jamo_t MED_COUNT  = 5'd21;
    localparam jamo_t FIN_COUNT  = 5'd28;

    localparam logic [15:0] SYL_BASE  = 16'hAC00;
    localparam logic [15:0] CONS_BASE = 16'h3131;
    localparam logic [15:0] VOW_BASE  = 16'h314F;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_BACK  = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        jamo_t init_idx;
        jamo_t med_idx;
        jamo_t fin_idx;
    } syl_state_t;

    localparam syl_state_t EMPTY_STATE = '{NO_JAMO, NO_JAMO, 5'd0};

    typedef struct packed {
        logic        commit_valid;
        logic [15:0] commit_char;
        logic        erase_back;
        logic        preedit_valid;
        logic [15:0] preedit_char;
    } result_t;

endpackage

@@ rtl/hts_if.sv @@
// Valid/ready channels for key words in and result words out.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
interface hts_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] key_code;
    logic       shift_held;

    modport source (output valid, mode, key_code, shift_held, input ready);
    modport sink   (input valid, mode, key_code, shift_held, output ready);
endinterface

interface hts_result_if;
    logic        valid;
    logic        ready;
    logic        commit_valid;
    logic [15:0] commit_char;
    logic        erase_back;
    logic        preedit_valid;
    logic [15:0] preedit_char;

    modport source (output valid, commit_valid, commit_char, erase_back,
                    preedit_valid, preedit_char, input ready);
    modport sink   (input valid, commit_valid, commit_char, erase_back,
                    preedit_valid, preedit_char, output ready);
endinterface

@@ rtl/hts_step.sv @@
// Combinational syllable automaton: next state and result for one word.
// Depends on hts_pkg.
`timescale 1ns / 1ps
module hts_step (
    input  hts_pkg::syl_state_t cur,
    input  logic [1:0]          mode,
    input  logic [7:0]          key_code,
    input  logic                shift_held,
    output hts_pkg::syl_state_t nxt,
    output hts_pkg::result_t    res
);
    import hts_pkg::*;

    typedef struct packed {
        jamo_t lead;
        jamo_t vow;
        jamo_t tail;
    } keymap_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] ch;
    } glyph_t;

    // letter key -> initial / medial / final indices
    function automatic keymap_t map_key(input logic [7:0] k, input logic sh);
        keymap_t r;
        r = '{NO_JAMO, NO_JAMO, 5'd0};
        case (k)
            8'd81: begin r.lead = sh ? 5'd8  : 5'd7;  r.tail = sh ? 5'd0  : 5'd17; end // Q
            8'd87: begin r.lead = sh ? 5'd13 : 5'd12; r.tail = sh ? 5'd0  : 5'd22; end // W
            8'd69: begin r.lead = sh ? 5'd4  : 5'd3;  r.tail = sh ? 5'd0  : 5'd7;  end // E
            8'd82: begin r.lead = sh ? 5'd1  : 5'd0;  r.tail = sh ? 5'd2  : 5'd1;  end // R
            8'd84: begin r.lead = sh ? 5'd10 : 5'd9;  r.tail = sh ? 5'd20 : 5'd19; end // T
            8'd89: r.vow = 5'd12;
            8'd85: r.vow = 5'd6;
            8'd73: r.vow = 5'd2;
            8'd79: r.vow = sh ? 5'd3 : 5'd1;
            8'd80: r.vow = sh ? 5'd7 : 5'd5;
            8'd65: begin r.lead = 5'd6;  r.tail = 5'd16; end
            8'd83: begin r.lead = 5'd2;  r.tail = 5'd4;  end
            8'd68: begin r.lead = 5'd11; r.tail = 5'd21; end
            8'd70: begin r.lead = 5'd5;  r.tail = 5'd8;  end
            8'd71: begin r.lead = 5'd18; r.tail = 5'd27; end
            8'd72: r.vow = 5'd8;
            8'd74: r.vow = 5'd4;
            8'd75: r.vow = 5'd0;
            8'd76: r.vow = 5'd20;
            8'd90: begin r.lead = 5'd15; r.tail = 5'd24; end
            8'd88: begin r.lead = 5'd16; r.tail = 5'd25; end
            8'd67: begin r.lead = 5'd14; r.tail = 5'd23; end
            8'd86: begin r.lead = 5'd17; r.tail = 5'd26; end
            8'd66: r.vow = 5'd16;
            8'd78: r.vow = 5'd13;
            8'd77: r.vow = 5'd18;
            default: r = '{NO_JAMO, NO_JAMO, 5'd0};
        endcase
        return r;
    endfunction

    function automatic jamo_t join_vowel(input jamo_t v, input jamo_t a);
        jamo_t j;
        j = NO_JAMO;
        if (v == 5'd8 && a == 5'd0)  j = 5'd9;
        if (v == 5'd8 && a == 5'd1)  j = 5'd10;
        if (v == 5'd8 && a == 5'd20) j = 5'd11;
        if (v == 5'd13 && a == 5'd4)  j = 5'd14;
        if (v == 5'd13 && a == 5'd5)  j = 5'd15;
        if (v == 5'd13 && a == 5'd20) j = 5'd16;
        if (v == 5'd18 && a == 5'd20) j = 5'd19;
        return j;
    endfunction

    function automatic jamo_t join_final(input jamo_t t, input jamo_t a);
        jamo_t j;
        j = 5'd0;
        if (t == 5'd1 && a == 5'd19) j = 5'd3;
        if (t == 5'd4 && a == 5'd22) j = 5'd5;
        if (t == 5'd4 && a == 5'd27) j = 5'd6;
        if (t == 5'd8) begin
            case (a)
                5'd1:    j = 5'd9;
                5'd16:   j = 5'd10;
                5'd17:   j = 5'd11;
                5'd19:   j = 5'd12;
                5'd25:   j = 5'd13;
                5'd26:   j = 5'd14;
                5'd27:   j = 5'd15;
                default: j = 5'd0;
            endcase
        end
        if (t == 5'd17 && a == 5'd19) j = 5'd18;
        return j;
    endfunction

    // final -> initial of the same consonant
    function automatic jamo_t final_as_initial(input jamo_t t);
        jamo_t r;
        case (t)
            5'd1:  r = 5'd0;
            5'd2:  r = 5'd1;
            5'd4:  r = 5'd2;
            5'd7:  r = 5'd3;
            5'd8:  r = 5'd5;
            5'd16: r = 5'd6;
            5'd17: r = 5'd7;
            5'd19: r = 5'd9;
            5'd20: r = 5'd10;
            5'd21: r = 5'd11;
            5'd22: r = 5'd12;
            5'd23: r = 5'd14;
            5'd24: r = 5'd15;
            5'd25: r = 5'd16;
            5'd26: r = 5'd17;
            5'd27: r = 5'd18;
            default: r = NO_JAMO;
        endcase
        return r;
    endfunction

    // initial of the part that moves on to the next syllable
    function automatic jamo_t trail_initial(input jamo_t t);
        jamo_t r;
        case (t)
            5'd3, 5'd12, 5'd18: r = 5'd9;
            5'd5:               r = 5'd12;
            5'd6, 5'd15:        r = 5'd18;
            5'd9:               r = 5'd0;
            5'd10:              r = 5'd6;
            5'd11:              r = 5'd7;
            5'd13:              r = 5'd16;
            5'd14:              r = 5'd17;
            default:            r = final_as_initial(t);
        endcase
        return r;
    endfunction

    // final left after the trailing part is peeled off
    function automatic jamo_t lead_final(input jamo_t t);
        jamo_t r;
        r = 5'd0;
        if (t == 5'd3) r = 5'd1;
        if (t == 5'd5 || t == 5'd6) r = 5'd4;
        if (t >= 5'd9 && t <= 5'd15) r = 5'd8;
        if (t == 5'd18) r = 5'd17;
        return r;
    endfunction

    function automatic jamo_t base_vowel(input jamo_t v);
        jamo_t r;
        r = NO_JAMO;
        if (v >= 5'd9 && v <= 5'd11)  r = 5'd8;
        if (v >= 5'd14 && v <= 5'd16) r = 5'd13;
        if (v == 5'd19) r = 5'd18;
        return r;
    endfunction

    // compatibility jamo offset from CONS_BASE for each initial
    function automatic logic [4:0] cons_offset(input jamo_t l);
        logic [4:0] r;
        case (l)
            5'd0:  r = 5'd0;
            5'd1:  r = 5'd1;
            5'd2:  r = 5'd3;
            5'd3:  r = 5'd6;
            5'd4:  r = 5'd7;
            5'd5:  r = 5'd8;
            5'd6:  r = 5'd16;
            5'd7:  r = 5'd17;
            5'd8:  r = 5'd18;
            5'd9:  r = 5'd20;
            5'd10: r = 5'd21;
            5'd11: r = 5'd22;
            5'd12: r = 5'd23;
            5'd13: r = 5'd24;
            5'd14: r = 5'd25;
            5'd15: r = 5'd26;
            5'd16: r = 5'd27;
            5'd17: r = 5'd28;
            5'd18: r = 5'd29;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // code point of a syllable state; valid low when empty
    function automatic glyph_t glyph_of(input syl_state_t s);
        glyph_t     g;
        logic [8:0] lv;
        jamo_t      t;
        g  = '0;
        t  = (s.fin_idx >= FIN_COUNT) ? 5'd0 : s.fin_idx;
        lv = {4'd0, s.init_idx} * 9'd21 + {4'd0, s.med_idx};
        if (s.init_idx >= INIT_COUNT) begin
            if (s.med_idx < MED_COUNT) begin
                g.valid = 1'b1;
                g.ch    = VOW_BASE + {11'd0, s.med_idx};
            end
        end else if (s.med_idx >= MED_COUNT) begin
            g.valid = 1'b1;
            g.ch    = CONS_BASE + {11'd0, cons_offset(s.init_idx)};
        end else begin
            g.valid = 1'b1;
            g.ch    = SYL_BASE + {7'd0, lv} * 16'd28 + {11'd0, t};
        end
        return g;
    endfunction

    keymap_t    km;
    logic       has_l;
    logic       has_v;
    logic       done;
    jamo_t      vj;
    jamo_t      fj;
    jamo_t      nl;
    syl_state_t peeled;
    glyph_t     commit_g;
    glyph_t     pre_g;
    logic       erase;

    assign km    = map_key(key_code, shift_held);
    assign has_l = cur.init_idx < INIT_COUNT;
    assign has_v = cur.med_idx < MED_COUNT;
    assign vj    = join_vowel(cur.med_idx, km.vow);
    assign fj    = join_final(cur.fin_idx, km.tail);
    assign nl    = trail_initial(cur.fin_idx);

    always_comb
    begin
        nxt      = cur;
        commit_g = '0;
        erase    = 1'b0;
        done     = 1'b0;
        peeled   = cur;
        case (mode_t'(mode))
            MODE_CLEAR: nxt = EMPTY_STATE;
            MODE_FLUSH:
            begin
                commit_g = glyph_of(cur);
                nxt      = EMPTY_STATE;
            end
            MODE_BACK:
            begin
                if (cur.fin_idx != 5'd0)
                    nxt.fin_idx = lead_final(cur.fin_idx);
                else if (has_v)
                    nxt.med_idx = base_vowel(cur.med_idx);
                else if (has_l)
                    nxt.init_idx = NO_JAMO;
                else
                    erase = 1'b1;
            end
            MODE_KEY:
            begin
                if (km.lead == NO_JAMO && km.vow == NO_JAMO) begin
                    commit_g = glyph_of(cur);
                    nxt      = EMPTY_STATE;
                end else if (km.vow != NO_JAMO) begin
                    if (has_l && !has_v) begin
                        nxt.med_idx = km.vow;
                        done        = 1'b1;
                    end else if (has_l && has_v && cur.fin_idx == 5'd0) begin
                        if (vj != NO_JAMO) begin
                            nxt.med_idx = vj;
                            done        = 1'b1;
                        end
                    end else if (has_l && has_v) begin
                        if (nl != NO_JAMO) begin
                            // trailing consonant moves on to the new syllable
                            peeled.fin_idx = lead_final(cur.fin_idx);
                            commit_g       = glyph_of(peeled);
                            nxt            = '{nl, km.vow, 5'd0};
                            done           = 1'b1;
                        end
                    end
                    if (!done) begin
                        commit_g = glyph_of(cur);
                        nxt      = '{NO_JAMO, km.vow, 5'd0};
                    end
                end else begin
                    if (has_l && has_v && km.tail != 5'd0) begin
                        if (cur.fin_idx == 5'd0) begin
                            nxt.fin_idx = km.tail;
                            done        = 1'b1;
                        end else if (fj != 5'd0) begin
                            nxt.fin_idx = fj;
                            done        = 1'b1;
                        end
                    end
                    if (!done) begin
                        commit_g = glyph_of(cur);
                        nxt      = '{km.lead, NO_JAMO, 5'd0};
                    end
                end
            end
            default: nxt = cur;
        endcase
    end

    assign pre_g = glyph_of(nxt);

    assign res.commit_valid  = commit_g.valid;
    assign res.commit_char   = commit_g.valid ? commit_g.ch : 16'd0;
    assign res.erase_back    = erase;
    assign res.preedit_valid = pre_g.valid;
    assign res.preedit_char  = pre_g.valid ? pre_g.ch : 16'd0;

endmodule

@@ rtl/hangul_two_set_composer.sv @@
// Key words pass the input register, then the result register. Throughput: one
// word per cycle unless the result channel stalls; the syllable state updates in
// the same cycle that the input register hands its word to the result register.
// Reset (rst_n low, asynchronous): both pipeline stages empty, syllable empty.
// Depends on hts_pkg, hts_if (channels) and hts_step (automaton logic).
`timescale 1ns / 1ps
module hangul_two_set_composer (
    input  logic                clk,
    input  logic                rst_n,
    hts_key_if.sink             keys,
    hts_result_if.source        result
);
    import hts_pkg::*;

    // Two register stages:
    //   input register  - holds the accepted key word
    //   result register - holds the finished result word
    // Both move together when the result register is free or being drained,
    // so a new key word is taken while a result still waits downstream.

    logic       in_vld_reg;
    logic [1:0] mode_reg;
    logic [7:0] key_reg;
    logic       shift_reg;

    syl_state_t state_reg;
    syl_state_t state_next;

    logic       out_vld_reg;
    result_t    res_reg;
    result_t    res_next;

    logic       advance;
    logic       take_in;

    // result stage can load when empty or being taken this cycle
    assign advance = !out_vld_reg || result.ready;
    // input stage can load when empty or its word moves on this cycle
    assign keys.ready = !in_vld_reg || advance;
    assign take_in    = keys.valid && keys.ready;

    hts_step u_step (
        .cur        (state_reg),
        .mode       (mode_reg),
        .key_code   (key_reg),
        .shift_held (shift_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // control: valid bits and the syllable state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= EMPTY_STATE;
        end else begin
            if (keys.ready)
                in_vld_reg <= keys.valid;
            if (advance) begin
                out_vld_reg <= in_vld_reg;
                // state only moves when a word is actually processed
                if (in_vld_reg)
                    state_reg <= state_next;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in) begin
            mode_reg  <= keys.mode;
            key_reg   <= keys.key_code;
            shift_reg <= keys.shift_held;
        end
        if (advance && in_vld_reg)
            res_reg <= res_next;
    end

    assign result.valid         = out_vld_reg;
    assign result.commit_valid  = res_reg.commit_valid;
    assign result.commit_char   = res_reg.commit_char;
    assign result.erase_back    = res_reg.erase_back;
    assign result.preedit_valid = res_reg.preedit_valid;
    assign result.preedit_char  = res_reg.preedit_char;

endmodule

@@ rtl/hts_checker.sv @@
// Port-level checks on the composer's result channel, bound to the top level.
// Depends on hangul_two_set_composer and its channel interfaces.
`timescale 1ns / 1ps
module hts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        commit_valid,
    input logic [15:0] commit_char,
    input logic        erase_back,
    input logic        preedit_valid,
    input logic [15:0] preedit_char
);

    // no committed character means a zero code point
    a_commit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !commit_valid |-> commit_char == 16'd0)
        else $error("commit_char set without commit_valid");

    // nothing composing means a zero preedit code point
    a_preedit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !preedit_valid |-> preedit_char == 16'd0)
        else $error("preedit_char set without preedit_valid");

    // a pass-through erase only happens on an empty syllable and leaves it empty
    a_erase_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && erase_back |-> !commit_valid && !preedit_valid)
        else $error("erase_back with a syllable present or committed");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(commit_char)
            && $stable(preedit_char) && $stable(commit_valid)
            && $stable(preedit_valid) && $stable(erase_back))
        else $error("result word changed while stalled");

endmodule

bind hangul_two_set_composer hts_checker u_hts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .commit_valid  (result.commit_valid),
    .commit_char   (result.commit_char),
    .erase_back    (result.erase_back),
    .preedit_valid (result.preedit_valid),
    .preedit_char  (result.preedit_char)
);

@@ verif/hangul_composer_checker.sv @@
// Syllable predictor and result comparator for the two-set Hangul composer.
// Depends on hts_pkg and hts_if; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps
module hangul_composer_checker (
    input  logic   clk,
    input  logic   rst_n,
    hts_key_if     keys,
    hts_result_if  result,
    output int     mismatch_count,
    output int     pending_words
);
    import hts_pkg::*;

    syl_state_t syl = EMPTY_STATE;
    result_t    expected_results [$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void decode_key(input logic [7:0] code, input logic sh,
                                       output jamo_t lead, output jamo_t vow,
                                       output jamo_t tail);
        lead = NO_JAMO;
        vow  = NO_JAMO;
        tail = 5'd0;
        case (code)
            8'd81: begin lead = sh ? 5'd8  : 5'd7;  tail = sh ? 5'd0  : 5'd17; end // Q
            8'd87: begin lead = sh ? 5'd13 : 5'd12; tail = sh ? 5'd0  : 5'd22; end // W
            8'd69: begin lead = sh ? 5'd4  : 5'd3;  tail = sh ? 5'd0  : 5'd7;  end // E
            8'd82: begin lead = sh ? 5'd1  : 5'd0;  tail = sh ? 5'd2  : 5'd1;  end // R
            8'd84: begin lead = sh ? 5'd10 : 5'd9;  tail = sh ? 5'd20 : 5'd19; end // T
            8'd89: vow = 5'd12;                                                   // Y
            8'd85: vow = 5'd6;                                                    // U
            8'd73: vow = 5'd2;                                                    // I
            8'd79: vow = sh ? 5'd3 : 5'd1;                                        // O
            8'd80: vow = sh ? 5'd7 : 5'd5;                                        // P
            8'd65: begin lead = 5'd6;  tail = 5'd16; end                          // A
            8'd83: begin lead = 5'd2;  tail = 5'd4;  end                          // S
            8'd68: begin lead = 5'd11; tail = 5'd21; end                          // D
            8'd70: begin lead = 5'd5;  tail = 5'd8;  end                          // F
            8'd71: begin lead = 5'd18; tail = 5'd27; end                          // G
            8'd72: vow = 5'd8;                                                    // H
            8'd74: vow = 5'd4;                                                    // J
            8'd75: vow = 5'd0;                                                    // K
            8'd76: vow = 5'd20;                                                   // L
            8'd90: begin lead = 5'd15; tail = 5'd24; end                          // Z
            8'd88: begin lead = 5'd16; tail = 5'd25; end                          // X
            8'd67: begin lead = 5'd14; tail = 5'd23; end                          // C
            8'd86: begin lead = 5'd17; tail = 5'd26; end                          // V
            8'd66: vow = 5'd16;                                                   // B
            8'd78: vow = 5'd13;                                                   // N
            8'd77: vow = 5'd18;                                                   // M
            default: ;
        endcase
    endfunction

    function automatic jamo_t vowel_compound(input jamo_t v, input jamo_t add);
        if (v == 5'd8  && add == 5'd0)  return 5'd9;
        if (v == 5'd8  && add == 5'd1)  return 5'd10;
        if (v == 5'd8  && add == 5'd20) return 5'd11;
        if (v == 5'd13 && add == 5'd4)  return 5'd14;
        if (v == 5'd13 && add == 5'd5)  return 5'd15;
        if (v == 5'd13 && add == 5'd20) return 5'd16;
        if (v == 5'd18 && add == 5'd20) return 5'd19;
        return NO_JAMO;
    endfunction

    // 0 means the two finals do not combine
    function automatic jamo_t final_compound(input jamo_t t, input jamo_t add);
        if (t == 5'd1 && add == 5'd19) return 5'd3;
        if (t == 5'd4 && add == 5'd22) return 5'd5;
        if (t == 5'd4 && add == 5'd27) return 5'd6;
        if (t == 5'd8) begin
            case (add)
                5'd1:    return 5'd9;
                5'd16:   return 5'd10;
                5'd17:   return 5'd11;
                5'd19:   return 5'd12;
                5'd25:   return 5'd13;
                5'd26:   return 5'd14;
                5'd27:   return 5'd15;
                default: return 5'd0;
            endcase
        end
        if (t == 5'd17 && add == 5'd19) return 5'd18;
        return 5'd0;
    endfunction

    // initial that the final (or its trailing part) becomes in the next syllable
    function automatic jamo_t carried_initial(input jamo_t t);
        case (t)
            5'd3, 5'd12, 5'd18: return 5'd9;
            5'd5:               return 5'd12;
            5'd6, 5'd15:        return 5'd18;
            5'd9:               return 5'd0;
            5'd10:              return 5'd6;
            5'd11:              return 5'd7;
            5'd13:              return 5'd16;
            5'd14:              return 5'd17;
            5'd1:               return 5'd0;
            5'd2:               return 5'd1;
            5'd4:               return 5'd2;
            5'd7:               return 5'd3;
            5'd8:               return 5'd5;
            5'd16:              return 5'd6;
            5'd17:              return 5'd7;
            5'd19:              return 5'd9;
            5'd20:              return 5'd10;
            5'd21:              return 5'd11;
            5'd22:              return 5'd12;
            5'd23:              return 5'd14;
            5'd24:              return 5'd15;
            5'd25:              return 5'd16;
            5'd26:              return 5'd17;
            5'd27:              return 5'd18;
            default:            return NO_JAMO;
        endcase
    endfunction

    // final left once the trailing part is peeled off
    function automatic jamo_t kept_final(input jamo_t t);
        if (t == 5'd3) return 5'd1;
        if (t == 5'd5 || t == 5'd6) return 5'd4;
        if (t >= 5'd9 && t <= 5'd15) return 5'd8;
        if (t == 5'd18) return 5'd17;
        return 5'd0;
    endfunction

    function automatic jamo_t vowel_root(input jamo_t v);
        if (v >= 5'd9 && v <= 5'd11) return 5'd8;
        if (v >= 5'd14 && v <= 5'd16) return 5'd13;
        if (v == 5'd19) return 5'd18;
        return NO_JAMO;
    endfunction

    function automatic logic [15:0] lone_consonant(input jamo_t l);
        case (l)
            5'd0:    return 16'h3131;
            5'd1:    return 16'h3132;
            5'd2:    return 16'h3134;
            5'd3:    return 16'h3137;
            5'd4:    return 16'h3138;
            5'd5:    return 16'h3139;
            5'd6:    return 16'h3141;
            5'd7:    return 16'h3142;
            5'd8:    return 16'h3143;
            5'd9:    return 16'h3145;
            5'd10:   return 16'h3146;
            5'd11:   return 16'h3147;
            5'd12:   return 16'h3148;
            5'd13:   return 16'h3149;
            5'd14:   return 16'h314A;
            5'd15:   return 16'h314B;
            5'd16:   return 16'h314C;
            5'd17:   return 16'h314D;
            default: return 16'h314E;
        endcase
    endfunction

    function automatic void syllable_glyph(input syl_state_t st, output logic ok,
                                           output logic [15:0] cp);
        int code;
        if (st.init_idx >= INIT_COUNT) begin
            ok = st.med_idx < MED_COUNT;
            cp = ok ? VOW_BASE + 16'(st.med_idx) : 16'h0;
        end else if (st.med_idx >= MED_COUNT) begin
            ok = 1'b1;
            cp = lone_consonant(st.init_idx);
        end else begin
            code = (int'(st.init_idx) * int'(MED_COUNT) + int'(st.med_idx)) * int'(FIN_COUNT)
                 + ((st.fin_idx >= FIN_COUNT) ? 0 : int'(st.fin_idx));
            ok = 1'b1;
            cp = SYL_BASE + 16'(code);
        end
    endfunction

    // Advances the syllable held in syl by one word and returns the result word.
    function automatic result_t compose_step(input mode_t m, input logic [7:0] code,
                                             input logic sh);
        result_t r;
        jamo_t   lead, vow, tail, joined, next_init;
        logic    has_init, has_med, done;
        r        = '0;
        done     = 1'b0;
        has_init = syl.init_idx < INIT_COUNT;
        has_med  = syl.med_idx < MED_COUNT;
        case (m)
            MODE_CLEAR: syl = EMPTY_STATE;
            MODE_FLUSH: begin
                syllable_glyph(syl, r.commit_valid, r.commit_char);
                syl = EMPTY_STATE;
            end
            MODE_BACK: begin
                if (syl.fin_idx > 5'd0)  syl.fin_idx  = kept_final(syl.fin_idx);
                else if (has_med)        syl.med_idx  = vowel_root(syl.med_idx);
                else if (has_init)       syl.init_idx = NO_JAMO;
                else                     r.erase_back = 1'b1;
            end
            default: begin
                decode_key(code, sh, lead, vow, tail);
                if (lead == NO_JAMO && vow == NO_JAMO) begin
                    syllable_glyph(syl, r.commit_valid, r.commit_char);
                    syl = EMPTY_STATE;
                end else if (vow != NO_JAMO) begin
                    if (has_init && !has_med) begin
                        syl.med_idx = vow;
                        done = 1'b1;
                    end else if (has_init && has_med && syl.fin_idx == 5'd0) begin
                        joined = vowel_compound(syl.med_idx, vow);
                        if (joined != NO_JAMO) begin
                            syl.med_idx = joined;
                            done = 1'b1;
                        end
                    end else if (has_init && has_med) begin
                        next_init = carried_initial(syl.fin_idx);
                        if (next_init != NO_JAMO) begin
                            syl.fin_idx = kept_final(syl.fin_idx);
                            syllable_glyph(syl, r.commit_valid, r.commit_char);
                            syl = '{next_init, vow, 5'd0};
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        syllable_glyph(syl, r.commit_valid, r.commit_char);
                        syl = EMPTY_STATE;
                        syl.med_idx = vow;
                    end
                end else begin
                    if (has_init && has_med && tail > 5'd0) begin
                        if (syl.fin_idx == 5'd0) begin
                            syl.fin_idx = tail;
                            done = 1'b1;
                        end else begin
                            joined = final_compound(syl.fin_idx, tail);
                            if (joined != 5'd0) begin
                                syl.fin_idx = joined;
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done) begin
                        syllable_glyph(syl, r.commit_valid, r.commit_char);
                        syl = EMPTY_STATE;
                        syl.init_idx = lead;
                    end
                end
            end
        endcase
        syllable_glyph(syl, r.preedit_valid, r.preedit_char);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            syl = EMPTY_STATE;
            expected_results.delete();
            pending_words = 0;
        end else begin
            if (result.valid && result.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result word, preedit_char",
                                    result.preedit_char, 16'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (result.commit_valid !== want.commit_valid)
                        report_mismatch("commit_valid", 16'(result.commit_valid),
                                        16'(want.commit_valid));
                    if (result.commit_char !== want.commit_char)
                        report_mismatch("commit_char", result.commit_char, want.commit_char);
                    if (result.erase_back !== want.erase_back)
                        report_mismatch("erase_back", 16'(result.erase_back),
                                        16'(want.erase_back));
                    if (result.preedit_valid !== want.preedit_valid)
                        report_mismatch("preedit_valid", 16'(result.preedit_valid),
                                        16'(want.preedit_valid));
                    if (result.preedit_char !== want.preedit_char)
                        report_mismatch("preedit_char", result.preedit_char,
                                        want.preedit_char);
                end
            end
            if (keys.valid && keys.ready)
                expected_results.push_back(compose_step(mode_t'(keys.mode), keys.key_code,
                                                        keys.shift_held));
            pending_words = expected_results.size();
        end
    end

endmodule

@@ verif/hangul_two_set_composer_tb.sv @@
// Testbench top for the two-set Hangul composer: clock, reset, key words and
// result back-pressure. Depends on hts_pkg, hts_if, the block and hangul_composer_checker.
`timescale 1ns / 1ps
module hangul_two_set_composer_tb;
    import hts_pkg::*;

    // Cycles with no word moving on either channel before the run is abandoned.
    // The longest legal quiet spell is the long receiver hold (HOLD_CYCLES).
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_WORDS = 750;

    logic clk;
    logic rst_n = 1'b0;
    int   mismatch_count;
    int   pending_words;
    int   words_sent  = 0;
    int   burst_left  = 0;
    logic hold_active = 1'b0;

    hts_key_if    keys_ch ();
    hts_result_if result_ch ();

    hangul_two_set_composer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_ch),
        .result (result_ch)
    );

    hangul_composer_checker u_syllable_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .keys           (keys_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one key word and returns at the edge where it is taken. Ready is
    // looked at on the falling edge, where nothing is changing, so the word is
    // known to go at the following rising edge. Pacing of bursts and gaps is
    // applied here too; during a long receiver hold the sender never gaps, so
    // the block fills and must stall its input.
    task automatic offer_word(input mode_t m, input logic [7:0] code, input logic sh);
        keys_ch.valid      <= 1'b1;
        keys_ch.mode       <= m;
        keys_ch.key_code   <= code;
        keys_ch.shift_held <= sh;
        @(negedge clk);
        while (!keys_ch.ready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 24);
            if (!hold_active && $urandom_range(0, 3) != 0)
            begin
                keys_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Stimulus: reset, a directed walk through the interesting cases, then
    // random typing that is mostly letters so syllables actually build up.
    initial
    begin
        int pick;
        keys_ch.valid      = 1'b0;
        keys_ch.mode       = MODE_KEY;
        keys_ch.key_code   = 8'd0;
        keys_ch.shift_held = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(MODE_BACK,  8'd0,   1'b0);   // backspace with nothing composed: erase
        offer_word(MODE_FLUSH, 8'd0,   1'b0);   // flush with nothing composed
        offer_word(MODE_KEY,   8'd255, 1'b1);   // unmapped key, all bits high
        offer_word(MODE_KEY,   8'd0,   1'b0);   // unmapped key, all bits low
        offer_word(MODE_KEY,   8'd75,  1'b0);   // K: lone vowel
        offer_word(MODE_KEY,   8'd79,  1'b1);   // shifted O after lone vowel: commits it
        offer_word(MODE_KEY,   8'd82,  1'b1);   // shifted R: doubled initial
        offer_word(MODE_KEY,   8'd72,  1'b0);   // H: medial
        offer_word(MODE_KEY,   8'd75,  1'b0);   // K: compound vowel
        offer_word(MODE_KEY,   8'd82,  1'b0);   // R: final
        offer_word(MODE_KEY,   8'd84,  1'b0);   // T: compound final
        offer_word(MODE_KEY,   8'd75,  1'b0);   // vowel splits the compound final
        offer_word(MODE_KEY,   8'd70,  1'b0);   // F: final
        offer_word(MODE_KEY,   8'd81,  1'b0);   // Q: compound final
        offer_word(MODE_BACK,  8'd0,   1'b0);   // peel compound part
        offer_word(MODE_BACK,  8'd0,   1'b0);   // peel final
        offer_word(MODE_BACK,  8'd0,   1'b0);   // peel medial
        offer_word(MODE_KEY,   8'd81,  1'b1);   // shifted Q: cannot be a final
        offer_word(MODE_KEY,   8'd80,  1'b1);   // shifted P: medial
        offer_word(MODE_KEY,   8'd87,  1'b1);   // shifted W after medial: commits, new syllable
        offer_word(MODE_KEY,   8'd89,  1'b1);   // Y with shift: shift has no effect
        offer_word(MODE_KEY,   8'd71,  1'b0);   // G: final
        offer_word(MODE_CLEAR, 8'd0,   1'b0);   // drop it silently
        offer_word(MODE_KEY,   8'd68,  1'b0);   // D: lone consonant
        offer_word(MODE_FLUSH, 8'd255, 1'b1);   // flush commits it

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                offer_word(MODE_KEY, 8'($urandom_range(65, 90)), $urandom_range(0, 3) == 0);
            else if (pick < 78)
                offer_word(MODE_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 90)
                offer_word(MODE_BACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 96)
                offer_word(MODE_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                offer_word(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        keys_ch.valid <= 1'b0;

        // Drain, then keep watching so a stray extra word would be caught.
        @(negedge clk);
        while (pending_words != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: switches between flowing, random and rhythmic stall patterns,
    // and twice holds ready low for a long spell while the sender keeps going.
    initial
    begin
        int   tick;
        int   pattern_sel;
        int   hold_left;
        int   next_hold_at;
        logic ready_now;
        tick         = 0;
        pattern_sel  = 0;
        hold_left    = 0;
        next_hold_at = 150;
        result_ch.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_left > 0)
            begin
                ready_now = 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_active = 1'b0;
            end
            else if (next_hold_at < 600 && words_sent >= next_hold_at)
            begin
                ready_now    = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                hold_active  = 1'b1;
                next_hold_at += 300;
            end
            else
            begin
                if (tick % 48 == 0)
                    pattern_sel = $urandom_range(0, 3);
                case (pattern_sel)
                    0:       ready_now = 1'b1;                          // no stalls
                    1:       ready_now = $urandom_range(0, 9) < 6;
                    2:       ready_now = (tick % 5) != 0;
                    default: ready_now = (tick % 7) < 3;                // mostly stalled
                endcase
            end
            tick++;
            result_ch.ready <= ready_now;
            @(posedge clk);
        end
    end

    // Watchdog: gives up once nothing has moved for as long as IDLE_LIMIT allows.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (keys_ch.valid && keys_ch.ready)
                || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
